### hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define DACC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// checked at every edge, reset included
`define DACC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

### hdl/dacc_pkg.sv
package dacc_pkg;

   localparam logic [9:0] WORD_MAX       = 10'd999;
   localparam logic [6:0] PC_LIMIT_RESET = 7'd10;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_EXEC  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   localparam logic [3:0] OPC_HLT = 4'd0;
   localparam logic [3:0] OPC_ADD = 4'd1;
   localparam logic [3:0] OPC_SUB = 4'd2;
   localparam logic [3:0] OPC_STA = 4'd3;
   localparam logic [3:0] OPC_LDA = 4'd5;
   localparam logic [3:0] OPC_BRA = 4'd6;
   localparam logic [3:0] OPC_BRZ = 4'd7;
   localparam logic [3:0] OPC_BRP = 4'd8;
   localparam logic [3:0] OPC_IO  = 4'd9;

   localparam logic [6:0] IO_INP = 7'd1;
   localparam logic [6:0] IO_OUT = 7'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] load_addr;
      logic [9:0] load_word;
      logic [9:0] in_value;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [9:0] out_value;
      logic [6:0] pc_now;
      logic [9:0] acc_now;
      logic       neg_flag;
      logic       halted;
   } rsp_type;

   typedef struct packed {
      logic [3:0] opc;
      logic [6:0] addr;
   } instr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_RESPOND
   } state_type;

   function automatic logic [9:0] sat_word(input logic [9:0] v);
      return (v > WORD_MAX) ? WORD_MAX : v;
   endfunction

   // hundreds digit by parallel compares, low two digits by subtraction
   function automatic instr_type decode_word(input logic [9:0] word);
      instr_type  d;
      logic [9:0] base;
      d.opc = '0;
      base  = '0;
      for (int i = 1; i <= 10; i++) begin
         if (word >= 10'(i * 100)) begin
            d.opc = 4'(i);
            base  = 10'(i * 100);
         end
      end
      d.addr = 7'(word - base);
      return d;
   endfunction

endpackage

### hdl/dacc_ram.sv
module dacc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dacc_exec.sv
module dacc_exec import dacc_pkg::*; #(
   parameter int MEM_WORDS = 100
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [6:0]                   pc_limit,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  req_type                      req_payload,
   input  logic                         slot_free,
   output logic                         push,
   output rsp_type                      push_payload,
   output logic                         ram_wr_en,
   output logic [$clog2(MEM_WORDS)-1:0] ram_addr,
   output logic [9:0]                   ram_wr_data,
   input  logic [9:0]                   ram_rd_data
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [6:0] MemWords7 = 7'(MEM_WORDS);

   state_type  state_ff, state_in;
   logic [6:0] pc_ff, pc_in;
   logic [9:0] acc_ff, acc_in;
   logic       neg_ff, neg_in;
   logic       halt_ff, halt_in;
   logic       emit_ff, emit_in;
   logic [9:0] in_value_ff, in_value_in;
   logic [3:0] opc_ff, opc_in;
   logic       opnd_zero_ff, opnd_zero_in;

   logic [6:0]  eff_limit;
   logic        take;
   instr_type   instr;
   logic        addr_ok;
   logic [9:0]  operand;
   logic [10:0] sum;

   assign eff_limit = (pc_limit < MemWords7) ? pc_limit : MemWords7;
   assign instr     = decode_word(ram_rd_data);
   assign addr_ok   = instr.addr < MemWords7;
   assign operand   = opnd_zero_ff ? 10'd0 : ram_rd_data;
   assign sum       = {1'b0, acc_ff} + {1'b0, operand};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         halt_ff  <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         halt_ff  <= halt_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_value_ff  <= in_value_in;
      opc_ff       <= opc_in;
      opnd_zero_ff <= opnd_zero_in;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      halt_in      = halt_ff;
      emit_in      = emit_ff;
      in_value_in  = in_value_ff;
      opc_in       = opc_ff;
      opnd_zero_in = opnd_zero_ff;
      req_ready    = 1'b0;
      push         = 1'b0;
      ram_wr_en    = 1'b0;
      ram_addr     = '0;
      ram_wr_data  = acc_ff;

      push_payload.out_valid = emit_ff;
      push_payload.out_value = emit_ff ? acc_ff : 10'd0;
      push_payload.pc_now    = pc_ff;
      push_payload.acc_now   = acc_ff;
      push_payload.neg_flag  = neg_ff;
      push_payload.halted    = halt_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DECODE: begin
            pc_in    = pc_ff + 7'd1;
            opc_in   = instr.opc;
            state_in = ST_RESPOND;
            case (instr.opc)
               OPC_HLT: begin
                  halt_in = 1'b1;
               end
               OPC_ADD, OPC_SUB, OPC_LDA: begin
                  ram_addr     = instr.addr[AW-1:0];
                  opnd_zero_in = !addr_ok;
                  state_in     = ST_EXEC;
               end
               OPC_STA: begin
                  ram_addr  = instr.addr[AW-1:0];
                  ram_wr_en = addr_ok;
               end
               OPC_BRA: begin
                  pc_in = instr.addr;
               end
               OPC_BRZ: begin
                  if (acc_ff == 10'd0) begin
                     pc_in = instr.addr;
                  end
               end
               OPC_BRP: begin
                  if (!neg_ff) begin
                     pc_in = instr.addr;
                  end
               end
               OPC_IO: begin
                  if (instr.addr == IO_INP) begin
                     acc_in = in_value_ff;
                  end else if (instr.addr == IO_OUT) begin
                     emit_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (state_in == ST_RESPOND && pc_in >= eff_limit) begin
               halt_in = 1'b1;
            end
         end
         ST_EXEC: begin
            case (opc_ff)
               OPC_ADD: begin
                  if (sum > {1'b0, WORD_MAX}) begin
                     acc_in = WORD_MAX;
                     neg_in = 1'b1;
                  end else begin
                     acc_in = sum[9:0];
                     neg_in = 1'b0;
                  end
               end
               OPC_SUB: begin
                  if (acc_ff < operand) begin
                     acc_in = '0;
                     neg_in = 1'b1;
                  end else begin
                     acc_in = acc_ff - operand;
                     neg_in = 1'b0;
                  end
               end
               OPC_LDA: begin
                  acc_in = operand;
               end
               default: begin
               end
            endcase
            if (pc_ff >= eff_limit) begin
               halt_in = 1'b1;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (slot_free) begin
               push      = 1'b1;
               req_ready = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      take = req_valid && req_ready;

      if (take) begin
         emit_in     = 1'b0;
         in_value_in = sat_word(req_payload.in_value);
         state_in    = ST_RESPOND;
         case (req_payload.op)
            OP_LOAD: begin
               ram_addr    = req_payload.load_addr[AW-1:0];
               ram_wr_data = sat_word(req_payload.load_word);
               ram_wr_en   = req_payload.load_addr < MemWords7;
            end
            OP_EXEC: begin
               if (halt_ff || pc_ff >= eff_limit) begin
                  halt_in = 1'b1;
               end else begin
                  ram_addr = pc_ff[AW-1:0];
                  state_in = ST_DECODE;
               end
            end
            OP_RESET: begin
               pc_in   = '0;
               acc_in  = '0;
               neg_in  = 1'b0;
               halt_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### hdl/decimal_accumulator_cpu_core_top.sv
// Decimal accumulator machine: a 100-word decimal memory (one single-port RAM with
// registered read) plus PC, accumulator, negative flag and halt flag. Every request
// transaction yields exactly one response transaction with the state after it. A
// load, a core reset or an execute while halted goes straight to the response, so
// such requests can stream at one per cycle while the output register is free. An
// execute of a branch, STA, INP, OUT or HLT fetches, then decodes; ADD, SUB and LDA
// add an execute step, needing a second read of the same RAM port for the operand.
// The response sits in an output register, so the next request is taken while the
// previous response is still waiting. pc_limit may only be written while idle.
module decimal_accumulator_cpu_core_top import dacc_pkg::*; #(
   parameter int MEM_WORDS = 100
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int AW = $clog2(MEM_WORDS);

   logic [6:0] pc_limit_ff, pc_limit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff, rsp_payload_in;

   logic          slot_free;
   logic          push;
   rsp_type       push_payload;
   logic          ram_wr_en;
   logic [AW-1:0] ram_addr;
   logic [9:0]    ram_wr_data;
   logic [9:0]    ram_rd_data;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pc_limit_in    = csr_wr_en ? csr_wr_data : pc_limit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = push_payload;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_limit_ff  <= PC_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_limit_ff  <= pc_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   dacc_exec #(
      .MEM_WORDS(MEM_WORDS)
   ) u_exec (
      .clock        (clock),
      .reset        (reset),
      .pc_limit     (pc_limit_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .slot_free    (slot_free),
      .push         (push),
      .push_payload (push_payload),
      .ram_wr_en    (ram_wr_en),
      .ram_addr     (ram_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_data  (ram_rd_data)
   );

   dacc_ram #(
      .WIDTH(10),
      .DEPTH(MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hdl/dacc_checker.sv
`include "assert_macros.svh"

module dacc_checker import dacc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a stalled response transaction holds
   `DACC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // no response right after reset
   `DACC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // output value is the accumulator when emitted and zero otherwise
   `DACC_ASSERT(a_out_value, clock, reset, rsp_valid |-> (rsp_payload.out_valid ? rsp_payload.out_value == rsp_payload.acc_now : rsp_payload.out_value == 10'd0))

   // accumulator stays decimal
   `DACC_ASSERT(a_acc_range, clock, reset, rsp_valid |-> rsp_payload.acc_now <= WORD_MAX)

   // a reset request taken from idle answers with a cleared core, through the response state and the output register
   `DACC_ASSERT(a_core_reset, clock, reset, req_valid && req_ready && req_payload.op == OP_RESET && !rsp_valid ##1 !rsp_valid |=> rsp_valid && rsp_payload.pc_now == 7'd0 && !rsp_payload.halted)

endmodule

bind decimal_accumulator_cpu_core_top dacc_checker u_checker (.*);
